// ===== hw/rtl/gsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsfp_pkg: shared types and constants of the Sync / follow-up pairing unit
// Commands, result kinds, pairing states, sequencer states and beat layouts.
// ----------------------------------------------------------------------------
package gsfp_pkg;

    typedef enum logic [1:0] {
        CMD_SYNC    = 2'd0,
        CMD_FUP     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_PAIR    = 2'd0;
    localparam logic [1:0] KIND_ALIVE   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [1:0] REG_JUMP    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_START   = 2'd2;

    typedef enum logic [1:0] {
        PS_EMPTY = 2'd0,
        PS_SYNC  = 2'd1,
        PS_FUP   = 2'd2
    } t_pair;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ORIG,
        S_MAST,
        S_FLAGS,
        S_DIVINIT,
        S_DIV,
        S_DIVFIN,
        S_OUT
    } t_state;

    localparam logic [63:0] NS_PER_SEC = 64'd1000000000;

    // input beat
    typedef struct packed {
        t_cmd        command;
        logic [15:0] seq_num;
        logic [63:0] corr_scaled;
        logic [63:0] rx_hw_ns;
        logic [62:0] mono_time_ns;
        logic [47:0] origin_seconds;
        logic [29:0] origin_nanoseconds;
        logic [15:0] src_port;
        logic [63:0] clk_ident;
    } t_msg;

    // result beat
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [63:0] master_time;
        logic [63:0] phase_offset;
        logic [62:0] sync_mono;
        logic [62:0] sync_rx_ns;
        logic [62:0] origin_total_ns;
        logic        jump_past;
        logic        jump_future;
        logic [15:0] paired_sequence;
        logic [15:0] master_port;
        logic [63:0] master_clock;
        logic [31:0] rate_ratio;
    } t_res;

endpackage

// ===== hw/rtl/gsfp_if.sv =====
// ----------------------------------------------------------------------------
// gsfp_if: valid/ready channel with a payload
// A beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface gsfp_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gptp_sync_followup_pairing_unit.sv =====
// ----------------------------------------------------------------------------
// gptp_sync_followup_pairing_unit: two-step Sync / follow-up pairing
// A Sync is taken with no result; a timeout check result is valid in the cycle
// after acceptance; a matched follow-up steps through S_ORIG, S_MAST and S_FLAGS,
// then S_DIVINIT, S_DIV, S_DIVFIN if the serial divider updates the ratio, and S_OUT.
// Throughput: one item at a time; the next beat is taken after the result
// leaves. Synchronous active-low reset empties the pairing, clears history,
// sets the ratio to one.
// ----------------------------------------------------------------------------
module gptp_sync_followup_pairing_unit #(
    parameter int RATIO_FRAC_BITS = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [62:0] i_cfg_data,
    gsfp_if.sink        i_in,
    gsfp_if.source      o_out
);
    import gsfp_pkg::*;

    localparam int QW = 64 + RATIO_FRAC_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic [QW-1:0] RMAX = QW'(64'hFFFF_FFFF);
    localparam logic [QW-1:0] ONE_W = QW'(1) << RATIO_FRAC_BITS;
    localparam logic [31:0] ONE_R = (ONE_W > RMAX) ? 32'hFFFF_FFFF
                                                    : ONE_W[31:0];

    // configuration
    logic [62:0] r_jump_thr, r_tout, r_start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_thr <= '0; r_tout <= '0; r_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_JUMP:    r_jump_thr <= i_cfg_data;
                REG_TIMEOUT: r_tout     <= i_cfg_data;
                REG_START:   r_start    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input payload fields
    logic [1:0]  in_cmd;
    logic [15:0] in_seq, in_port;
    logic [63:0] in_corr, in_rx, in_clock;
    logic [62:0] in_mono;
    logic [47:0] in_osec;
    logic [29:0] in_onsec;
    assign in_cmd   = i_in.data.command;
    assign in_seq   = i_in.data.seq_num;
    assign in_corr  = i_in.data.corr_scaled;
    assign in_rx    = i_in.data.rx_hw_ns;
    assign in_mono  = i_in.data.mono_time_ns;
    assign in_osec  = i_in.data.origin_seconds;
    assign in_onsec = i_in.data.origin_nanoseconds;
    assign in_port  = i_in.data.src_port;
    assign in_clock = i_in.data.clk_ident;

    t_state r_state, n_state;
    t_pair  r_pair;
    logic [15:0] r_h_seq, r_h_port;
    logic [63:0] r_h_corr, r_h_rx, r_h_clock;
    logic [62:0] r_h_mono, r_last_mono;
    logic [63:0] r_prev_master, r_prev_rx, r_prev_orig;
    logic        r_have_prev;
    logic [31:0] r_ratio;

    // working registers of the current follow-up
    logic [15:0] r_f_seq;
    logic [63:0] r_f_corr;
    logic [62:0] r_f_mono;
    logic [47:0] r_osec;
    logic [63:0] r_acc, r_master, r_orig;
    logic [1:0]  r_mstep;
    logic        r_jp, r_jf;
    logic [QW-1:0] r_q;
    logic [64:0]   r_rem;
    logic [63:0]   r_dvs;
    logic [CW-1:0] r_cnt;

    // result register
    logic        r_ov;
    logic [1:0]  r_kind;

    logic accept;
    assign accept = i_in.valid && i_in.ready;

    // shared 64-bit adder: one sum per cycle under the sequencer
    logic [63:0] add_a, add_b, add_s;
    logic [31:0] pp_a;
    logic [63:0] pp;
    always_comb begin
        pp_a  = 32'd0;
        add_a = 64'd0;
        add_b = 64'd0;
        unique case (r_state)
            S_ORIG: begin
                // seconds * 1e9 in 16-bit slices of the seconds
                unique case (r_mstep)
                    2'd0:    pp_a = {16'd0, r_osec[15:0]};
                    2'd1:    pp_a = {16'd0, r_osec[31:16]};
                    default: pp_a = {16'd0, r_osec[47:32]};
                endcase
                add_a = r_acc;
            end
            S_MAST: begin
                add_a = r_acc;
                add_b = {{16{r_h_corr[63]}}, r_h_corr[63:16]};
            end
            default: ;
        endcase
        pp = 64'(pp_a) * NS_PER_SEC;
        if (r_state == S_ORIG)
            add_b = pp << (6'(r_mstep) * 6'd16);
        add_s = add_a + add_b;
    end

    function automatic logic s_lt(input logic [63:0] a, input logic [63:0] b);
        s_lt = $signed(a) < $signed(b);
    endfunction

    // ratio is refreshed only when both intervals are positive
    logic upd_now;
    assign upd_now = r_have_prev && s_lt(r_prev_rx, r_h_rx) && s_lt(r_prev_orig, r_master);

    // divide step
    logic [64:0] rem_sh;
    logic        dbit;
    always_comb begin
        rem_sh = {r_rem[63:0], r_q[QW-1]};
        dbit   = rem_sh >= {1'b0, r_dvs};
    end

    logic in_ready;
    assign in_ready = (r_state == S_IDLE) && !r_ov;
    assign i_in.ready = in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:
                if (accept && in_cmd == CMD_FUP && r_pair == PS_SYNC && r_h_seq == in_seq)
                    n_state = S_ORIG;
            S_ORIG:    if (r_mstep == 2'd2) n_state = S_MAST;
            S_MAST:    if (r_mstep == 2'd1) n_state = S_FLAGS;
            S_FLAGS:   n_state = upd_now ? S_DIVINIT : S_OUT;
            S_DIVINIT: n_state = S_DIV;
            S_DIV:     if (r_cnt == CW'(1)) n_state = S_DIVFIN;
            S_DIVFIN:  n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // datapath and history
    logic [62:0] ref_mono;
    assign ref_mono = r_have_prev ? r_last_mono : r_start;
    logic [63:0] mdiff;
    assign mdiff = r_master - r_prev_master;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= PS_EMPTY; r_last_mono <= '0; r_prev_master <= '0;
            r_have_prev <= 1'b0; r_prev_rx <= '0; r_prev_orig <= '0;
            r_ratio <= ONE_R; r_ov <= 1'b0; r_kind <= KIND_PAIR;
        end else begin
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (accept) begin
                    unique case (in_cmd)
                        CMD_SYNC: begin
                            r_h_seq <= in_seq; r_h_corr <= in_corr; r_h_rx <= in_rx;
                            r_h_mono <= in_mono; r_h_port <= in_port;
                            r_h_clock <= in_clock; r_pair <= PS_SYNC;
                        end
                        CMD_TIMEOUT: begin
                            r_ov <= 1'b1;
                            r_kind <= (r_tout != '0 && in_mono > ref_mono &&
                                       (in_mono - ref_mono) > r_tout)
                                      ? KIND_TIMEOUT : KIND_ALIVE;
                        end
                        CMD_FUP: begin
                            if (r_pair == PS_SYNC && r_h_seq == in_seq) begin
                                r_f_seq <= in_seq; r_f_corr <= in_corr;
                                r_f_mono <= in_mono; r_osec <= in_osec;
                                r_acc <= {34'd0, in_onsec}; r_mstep <= 2'd0;
                            end else begin
                                r_pair <= PS_FUP;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ORIG: begin
                    r_acc <= add_s;
                    r_mstep <= (r_mstep == 2'd2) ? 2'd0 : r_mstep + 2'd1;
                    if (r_mstep == 2'd2) r_orig <= add_s;
                end
                S_MAST: begin
                    // second pass adds the follow-up correction
                    if (r_mstep == 2'd0) begin
                        r_acc <= add_s;
                        r_h_corr <= r_f_corr;
                        r_mstep <= 2'd1;
                    end else begin
                        r_master <= add_s;
                        r_mstep <= 2'd0;
                    end
                end
                S_FLAGS: begin
                    r_jp <= r_have_prev && s_lt(r_master, r_prev_master);
                    r_jf <= r_have_prev && !s_lt(r_master, r_prev_master) &&
                            r_jump_thr != '0 && mdiff > {1'b0, r_jump_thr};
                    r_q   <= {r_h_rx - r_prev_rx, {RATIO_FRAC_BITS{1'b0}}};
                    r_dvs <= r_master - r_prev_orig;
                end
                S_DIVINIT: begin
                    r_rem <= '0;
                    r_cnt <= CW'(QW);
                end
                S_DIV: begin
                    r_rem <= dbit ? rem_sh - {1'b0, r_dvs} : rem_sh;
                    r_q   <= {r_q[QW-2:0], dbit};
                    r_cnt <= r_cnt - CW'(1);
                end
                S_DIVFIN: r_ratio <= (r_q > RMAX) ? 32'hFFFF_FFFF : r_q[31:0];
                S_OUT: begin
                    r_prev_rx <= r_h_rx; r_prev_orig <= r_master;
                    r_prev_master <= r_master; r_have_prev <= 1'b1;
                    r_pair <= PS_EMPTY; r_last_mono <= r_f_mono;
                    r_ov <= 1'b1; r_kind <= KIND_PAIR;
                end
                default: ;
            endcase
        end
    end

    // output beat
    logic pair_k;
    assign pair_k = (r_kind == KIND_PAIR);
    assign o_out.valid = r_ov;
    always_comb begin
        o_out.data.result_kind     = r_kind;
        o_out.data.master_time     = pair_k ? r_prev_master : 64'd0;
        o_out.data.phase_offset    = pair_k ? r_h_rx - r_prev_master : 64'd0;
        o_out.data.sync_mono       = pair_k ? r_h_mono : 63'd0;
        o_out.data.sync_rx_ns      = (pair_k && !r_h_rx[63]) ? r_h_rx[62:0] : 63'd0;
        o_out.data.origin_total_ns = (pair_k && !r_orig[63]) ? r_orig[62:0] : 63'd0;
        o_out.data.jump_past       = pair_k && r_jp;
        o_out.data.jump_future     = pair_k && r_jf;
        o_out.data.paired_sequence = pair_k ? r_f_seq : 16'd0;
        o_out.data.master_port     = pair_k ? r_h_port : 16'd0;
        o_out.data.master_clock    = pair_k ? r_h_clock : 64'd0;
        o_out.data.rate_ratio      = pair_k ? r_ratio : 32'd0;
    end

endmodule

// ===== tb/sv/gptp_sync_followup_pairing_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gptp_sync_followup_pairing_unit_tb: self-checking bench for Sync/follow-up pairing
// A table of directed messages is walked first, then mostly well-formed
// Sync/follow-up exchanges with timeout checks and noise, under four register
// settings. Every result beat is checked field by field against an in-bench
// pairing predictor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module gptp_sync_followup_pairing_unit_tb;
    import gsfp_pkg::*;

    localparam int          FRAC       = 30;
    localparam int          SETTLE     = 200;
    localparam int          CYCLE_CAP  = 2000000;
    localparam int          PHASE_MSGS = 140;
    localparam logic [62:0] MAX63      = {63{1'b1}};

    typedef struct {
        t_msg       m;
        bit         typed;
        logic [1:0] kind;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [62:0] i_cfg_data = '0;

    gsfp_if #(.T(t_msg)) msg_ch ();
    gsfp_if #(.T(t_res)) res_ch ();

    gptp_sync_followup_pairing_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (msg_ch.sink),
        .o_out       (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers and pairing state
    logic [62:0] cf_jump, cf_timeout, cf_start;
    t_pair       pm_state;
    logic [15:0] pm_seq, pm_port;
    logic [63:0] pm_corr, pm_rx, pm_clock;
    logic [62:0] pm_mono, pm_last_pair;
    logic [63:0] pm_prev_master, pm_prev_rx, pm_prev_origin;
    logic        pm_have_prev;
    logic [31:0] pm_ratio;

    t_res pending_results[$];
    int   errors = 0;
    int   results_seen = 0;
    int   pairs_seen = 0;
    int   timeouts_seen = 0;
    int   cycles = 0;
    int   burst_left = 0;

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("ERROR t=%0t %s: got %h expected %h", $realtime, field, got, want);
    endtask

    function automatic logic [63:0] corr_ns(logic [63:0] c);
        return $signed(c) >>> 16;
    endfunction

    function automatic logic [31:0] rate_div(logic [63:0] s, logic [63:0] m);
        logic [127:0] q;
        q = ({64'd0, s} << FRAC) / {64'd0, m};
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // advance the pairing model by one message
    task automatic predict(input t_msg m, output bit has, output t_res r);
        logic [63:0] origin, master;
        logic [62:0] ref_mono;
        r   = '0;
        has = 1'b0;
        case (m.command)
            CMD_SYNC: begin
                pm_seq   = m.seq_num;
                pm_corr  = m.corr_scaled;
                pm_rx    = m.rx_hw_ns;
                pm_mono  = m.mono_time_ns;
                pm_port  = m.src_port;
                pm_clock = m.clk_ident;
                pm_state = PS_SYNC;
            end
            CMD_TIMEOUT: begin
                ref_mono = pm_have_prev ? pm_last_pair : cf_start;
                has = 1'b1;
                r.result_kind = (cf_timeout != 0 && m.mono_time_ns > ref_mono
                                 && (m.mono_time_ns - ref_mono) > cf_timeout)
                                ? KIND_TIMEOUT : KIND_ALIVE;
            end
            CMD_FUP: begin
                if (pm_state != PS_SYNC || pm_seq != m.seq_num) begin
                    pm_state = PS_FUP;
                end else begin
                    origin = m.origin_seconds * NS_PER_SEC + 64'(m.origin_nanoseconds);
                    master = origin + corr_ns(pm_corr) + corr_ns(m.corr_scaled);
                    if (pm_have_prev) begin
                        if ($signed(master) < $signed(pm_prev_master))
                            r.jump_past = 1'b1;
                        else if (cf_jump != 0 && (master - pm_prev_master) > 64'(cf_jump))
                            r.jump_future = 1'b1;
                        if ($signed(pm_prev_rx) < $signed(pm_rx)
                            && $signed(pm_prev_origin) < $signed(master))
                            pm_ratio = rate_div(pm_rx - pm_prev_rx, master - pm_prev_origin);
                    end
                    pm_prev_rx     = pm_rx;
                    pm_prev_origin = master;
                    pm_prev_master = master;
                    pm_have_prev   = 1'b1;
                    pm_state       = PS_EMPTY;
                    pm_last_pair   = m.mono_time_ns;
                    has               = 1'b1;
                    r.result_kind     = KIND_PAIR;
                    r.master_time     = master;
                    r.phase_offset    = pm_rx - master;
                    r.sync_mono       = pm_mono;
                    r.sync_rx_ns      = pm_rx[63] ? '0 : pm_rx[62:0];
                    r.origin_total_ns = origin[63] ? '0 : origin[62:0];
                    r.paired_sequence = m.seq_num;
                    r.master_port     = pm_port;
                    r.master_clock    = pm_clock;
                    r.rate_ratio      = pm_ratio;
                end
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(logic [1:0] idx, logic [62:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_JUMP:    cf_jump = val;
            REG_TIMEOUT: cf_timeout = val;
            default:     cf_start = val;
        endcase
    endtask

    task automatic configure(logic [62:0] jump, logic [62:0] tmo, logic [62:0] start);
        write_reg(REG_JUMP, jump);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_START, start);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // send one message, honoring bursts and gaps; predict on acceptance
    task automatic send(t_msg m, bit typed, logic [1:0] kind);
        bit   has;
        t_res r;
        if (burst_left == 0) begin
            msg_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 12) : 0) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        msg_ch.valid <= 1'b1;
        msg_ch.data  <= m;
        do @(posedge i_clk); while (!msg_ch.ready);
        predict(m, has, r);
        if (has) begin
            if (typed) begin
                r = '0;
                r.result_kind = kind;
            end
            pending_results.push_back(r);
        end
    endtask

    task automatic drain();
        msg_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_msg mk(t_cmd c, logic [15:0] seq, logic [63:0] corr,
                                logic [63:0] rx, logic [62:0] mono, logic [47:0] osec,
                                logic [29:0] onsec, logic [15:0] port, logic [63:0] clk);
        t_msg m;
        m = '{c, seq, corr, rx, mono, osec, onsec, port, clk};
        return m;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_msg rnd_msg(t_cmd c);
        return mk(c, 16'($urandom), rnd64(), rnd64(), 63'(rnd64()),
                  48'(rnd64()), 30'($urandom_range(999999999)), 16'($urandom), rnd64());
    endfunction

    // receiver stall pattern: runs of free flow and of random stalls
    int stall_mode = 0;
    int stall_run  = 0;
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run  <= $urandom_range(5, 60);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
            default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("ERROR t=%0t unexpected result beat %h", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (want.result_kind == KIND_PAIR) pairs_seen++;
                if (want.result_kind == KIND_TIMEOUT) timeouts_seen++;
                if (got.result_kind != want.result_kind)
                    report("result_kind", 64'(got.result_kind), 64'(want.result_kind));
                if (got.master_time != want.master_time)
                    report("master_time", got.master_time, want.master_time);
                if (got.phase_offset != want.phase_offset)
                    report("phase_offset", got.phase_offset, want.phase_offset);
                if (got.sync_mono != want.sync_mono)
                    report("sync_mono", 64'(got.sync_mono), 64'(want.sync_mono));
                if (got.sync_rx_ns != want.sync_rx_ns)
                    report("sync_rx_ns", 64'(got.sync_rx_ns), 64'(want.sync_rx_ns));
                if (got.origin_total_ns != want.origin_total_ns)
                    report("origin_total_ns", 64'(got.origin_total_ns),
                           64'(want.origin_total_ns));
                if (got.jump_past != want.jump_past)
                    report("jump_past", 64'(got.jump_past), 64'(want.jump_past));
                if (got.jump_future != want.jump_future)
                    report("jump_future", 64'(got.jump_future), 64'(want.jump_future));
                if (got.paired_sequence != want.paired_sequence)
                    report("paired_sequence", 64'(got.paired_sequence),
                           64'(want.paired_sequence));
                if (got.master_port != want.master_port)
                    report("master_port", 64'(got.master_port), 64'(want.master_port));
                if (got.master_clock != want.master_clock)
                    report("master_clock", got.master_clock, want.master_clock);
                if (got.rate_ratio != want.rate_ratio)
                    report("rate_ratio", 64'(got.rate_ratio), 64'(want.rate_ratio));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // realistic exchange: slave clock t, master offset and small corrections
    logic [63:0] sim_t, mast_off;
    logic [62:0] mono_t;
    logic [15:0] seq_ctr;

    task automatic exchange(bit wild);
        t_msg s, f;
        logic [63:0] origin;
        sim_t  += $urandom_range(1, 4000);
        mono_t += $urandom_range(1, 4000);
        origin  = sim_t + mast_off + $urandom_range(0, 50);
        if ($urandom_range(0, 9) == 0) origin -= $urandom_range(0, 20000);
        s = mk(CMD_SYNC, seq_ctr, 64'($signed($urandom_range(0, 65535 * 200))) - 64'd6553600,
               sim_t, mono_t, 48'(origin / NS_PER_SEC), 30'(origin % NS_PER_SEC),
               16'($urandom), rnd64());
        f = s;
        f.command      = CMD_FUP;
        f.corr_scaled  = 64'($urandom_range(0, 65535 * 100));
        f.mono_time_ns = mono_t + $urandom_range(0, 100);
        if (wild) begin
            s = rnd_msg(CMD_SYNC);
            f = rnd_msg(CMD_FUP);
            f.seq_num = s.seq_num;
        end
        send(s, 1'b0, KIND_PAIR);
        if ($urandom_range(0, 15) == 0) send(rnd_msg(CMD_NONE), 1'b0, KIND_PAIR);
        send(f, 1'b0, KIND_PAIR);
        seq_ctr++;
    endtask

    task automatic random_phase(int count);
        t_msg m;
        int   sel;
        sim_t    = {24'd0, $urandom, 8'd0};
        mast_off = 64'($urandom_range(0, 1000000)) - 64'd500000;
        mono_t   = 63'($urandom) + cf_start;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                exchange(1'b0);
            end else if (sel < 66) begin
                exchange(1'b1);
            end else if (sel < 80) begin
                m = rnd_msg(CMD_TIMEOUT);
                m.mono_time_ns = pm_have_prev ? pm_last_pair : cf_start;
                m.mono_time_ns += 63'($urandom_range(0, 12000)) - 63'd2000;
                send(m, 1'b0, KIND_PAIR);
            end else if (sel < 88) begin
                m = rnd_msg(CMD_FUP);
                m.seq_num = seq_ctr + 16'($urandom_range(1, 3));
                send(m, 1'b0, KIND_PAIR);
            end else if (sel < 92) begin
                send(rnd_msg(CMD_NONE), 1'b0, KIND_PAIR);
                n--;
            end else begin
                send(rnd_msg(t_cmd'($urandom_range(0, 2))), 1'b0, KIND_PAIR);
            end
        end
    endtask

    t_row dir_rows[$];

    initial begin
        msg_ch.valid = 1'b0;
        msg_ch.data  = '0;
        cf_jump = '0; cf_timeout = '0; cf_start = '0;
        pm_state = PS_EMPTY; pm_have_prev = 1'b0;
        pm_seq = '0; pm_port = '0; pm_corr = '0; pm_rx = '0; pm_clock = '0;
        pm_mono = '0; pm_last_pair = '0;
        pm_prev_master = '0; pm_prev_rx = '0; pm_prev_origin = '0;
        pm_ratio = 32'(64'd1 << FRAC);
        seq_ctr = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, extremes, broken sequences, jumps, clamps
        dir_rows = '{
            '{mk(CMD_TIMEOUT, 0, 0, 0, MAX63, 0, 0, 0, 0), 1, KIND_ALIVE},
            '{mk(CMD_FUP, 0, 0, 0, 0, 0, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_SYNC, 0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, MAX63,
                 0, 0, 16'hFFFF, '1), 0, KIND_PAIR},
            '{mk(CMD_FUP, 1, 0, 0, 5, 0, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_FUP, 0, 0, 0, 6, 0, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_SYNC, 16'hFFFF, 0, -64'sd5, 100, 0, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_FUP, 16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, 200, '1, 999999999,
                 0, 0), 0, KIND_PAIR},
            '{mk(CMD_SYNC, 2, 64'd65536, 1000, 300, 0, 0, 7, 64'h1234), 0, KIND_PAIR},
            '{mk(CMD_FUP, 2, 0, 0, 400, 1, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_SYNC, 3, 0, 2000, 500, 0, 0, 7, 64'h1234), 0, KIND_PAIR},
            '{mk(CMD_FUP, 3, 0, 0, 600, 1, 500, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_NONE, 3, '1, '1, MAX63, '1, '1, '1, '1), 0, KIND_PAIR},
            '{mk(CMD_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0), 1, KIND_ALIVE},
            '{mk(CMD_SYNC, 4, 0, 3000, 700, 0, 0, 1, 1), 0, KIND_PAIR},
            '{mk(CMD_SYNC, 5, 0, 3100, 710, 0, 0, 2, 2), 0, KIND_PAIR},
            '{mk(CMD_FUP, 4, 0, 0, 720, 2, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_FUP, 5, 0, 0, 730, 2, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_SYNC, 6, -64'sd65537, 4000, 800, 0, 0, 3, 3), 0, KIND_PAIR},
            '{mk(CMD_FUP, 6, -64'sd1, 0, 900, 0, 0, 0, 0), 0, KIND_PAIR},
            '{mk(CMD_SYNC, 7, 0, 9000, 1000, 0, 0, 4, 4), 0, KIND_PAIR},
            '{mk(CMD_FUP, 7, 0, 0, 1100, 3, 0, 0, 0), 0, KIND_PAIR}
        };
        foreach (dir_rows[k]) send(dir_rows[k].m, dir_rows[k].typed, dir_rows[k].kind);
        drain();

        random_phase(PHASE_MSGS);
        drain();
        configure(63'd1000, 63'd5000, 63'd100);
        random_phase(PHASE_MSGS);
        drain();
        configure(MAX63, MAX63, MAX63);
        random_phase(PHASE_MSGS);
        drain();
        configure(63'd1, 63'd1, 63'd0);
        random_phase(PHASE_MSGS);
        drain();

        $display("Covered %0d result beats: %0d pairings, %0d timeouts, over 4 register settings.",
                 results_seen, pairs_seen, timeouts_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
